// ===== rtl/camsplit_pkg.sv =====
`default_nettype none
package camsplit_pkg;

   localparam int REQ_TDATA_W = 80;
   localparam int RSP_TDATA_W = 72;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 12;
   localparam int WIN_W       = 11;
   localparam int FIELD_W     = 12;
   localparam int COUNT_W     = 4;
   localparam int OUT_XY_W    = 11;
   localparam int OUT_CX_W    = 10;

   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_MOVE = 1'b1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_WIN_LEFT   = 3'd0,
      CSR_WIN_TOP    = 3'd1,
      CSR_WIN_WIDTH  = 3'd2,
      CSR_WIN_HEIGHT = 3'd3,
      CSR_ORIGIN_X   = 3'd4,
      CSR_ORIGIN_Y   = 3'd5,
      CSR_RECT_COUNT = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic capture;   // input transfer
      logic m1;
      logic m2;
      logic m3;
      logic rd;        // store read
      logic src_calc;
      logic dst_calc;
      logic pair_load; // computed blit into the pending register
      logic out_load;  // pending blit into the output register
      logic out_last;
   } cmd_type;

   typedef struct packed {
      logic ok;
      logic s_hit;
      logic d_hit;
   } stat_type;

endpackage
`default_nettype wire

// ===== rtl/camsplit_dpath.sv =====
`default_nettype none
module camsplit_dpath #(
   parameter int MAX_RECTS  = 8,
   parameter int COORD_BITS = 11,
   parameter int IXW        = 3,
   parameter int CW         = 4
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_valid,
   input  wire logic [camsplit_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [camsplit_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  wire logic                                req_tuser,
   input  wire logic [camsplit_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  wire camsplit_pkg::cmd_type               cmd,
   input  wire logic [IXW-1:0]                      rd_index,
   output camsplit_pkg::stat_type                   stat,
   output logic [CW-1:0]                            slot_count,
   output logic [camsplit_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   output logic                                     rsp_tlast
);
   import camsplit_pkg::*;

   localparam int IW = ((COORD_BITS > 13) ? COORD_BITS : 13) + 3;
   localparam int EW = (COORD_BITS > 12) ? COORD_BITS : 12;

   typedef logic signed [IW-1:0] ival_type;

   // configuration
   logic [WIN_W-1:0]          win_left_ff, win_top_ff, win_width_ff, win_height_ff;
   logic signed [FIELD_W-1:0] org_x_ff, org_y_ff;
   logic [COUNT_W-1:0]        rect_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_left_ff   <= '0;
         win_top_ff    <= '0;
         win_width_ff  <= '0;
         win_height_ff <= '0;
         org_x_ff      <= '0;
         org_y_ff      <= '0;
         rect_count_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_WIN_LEFT:   win_left_ff   <= csr_wdata[WIN_W-1:0];
            CSR_WIN_TOP:    win_top_ff    <= csr_wdata[WIN_W-1:0];
            CSR_WIN_WIDTH:  win_width_ff  <= csr_wdata[WIN_W-1:0];
            CSR_WIN_HEIGHT: win_height_ff <= csr_wdata[WIN_W-1:0];
            CSR_ORIGIN_X:   org_x_ff      <= csr_wdata;
            CSR_ORIGIN_Y:   org_y_ff      <= csr_wdata;
            CSR_RECT_COUNT: rect_count_ff <= csr_wdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   assign slot_count = (32'(rect_count_ff) > MAX_RECTS) ? CW'(MAX_RECTS) : CW'(rect_count_ff);

   // input fields
   logic [2:0]                in_index;
   logic                      in_present, in_inv;
   logic signed [FIELD_W-1:0] in_x0, in_y0, in_x1, in_y1, in_w, in_h;

   assign in_index   = req_tdata[2:0];
   assign in_present = req_tdata[3];
   assign in_x0      = req_tdata[15:4];
   assign in_y0      = req_tdata[27:16];
   assign in_x1      = req_tdata[39:28];
   assign in_y1      = req_tdata[51:40];
   assign in_w       = req_tdata[63:52];
   assign in_h       = req_tdata[75:64];
   assign in_inv     = req_tdata[76];

   // rectangle store
   logic                  st_present [MAX_RECTS];
   logic [COORD_BITS-1:0] st_left [MAX_RECTS];
   logic [COORD_BITS-1:0] st_upper [MAX_RECTS];
   logic [COORD_BITS-1:0] st_right [MAX_RECTS];
   logic [COORD_BITS-1:0] st_lower [MAX_RECTS];
   logic [EW-1:0]         e_left, e_upper, e_right, e_lower;

   assign e_left  = EW'(unsigned'(in_x0));
   assign e_upper = EW'(unsigned'(in_y0));
   assign e_right = EW'(unsigned'(in_x1));
   assign e_lower = EW'(unsigned'(in_y1));

   always_ff @(posedge clock) begin
      if (cmd.capture && req_tuser == REQ_LOAD && 32'(in_index) < MAX_RECTS) begin
         st_present[in_index[IXW-1:0]] <= in_present;
         st_left[in_index[IXW-1:0]]    <= e_left[COORD_BITS-1:0];
         st_upper[in_index[IXW-1:0]]   <= e_upper[COORD_BITS-1:0];
         st_right[in_index[IXW-1:0]]   <= e_right[COORD_BITS-1:0];
         st_lower[in_index[IXW-1:0]]   <= e_lower[COORD_BITS-1:0];
      end
   end

   logic                  rd_present_ff;
   logic [COORD_BITS-1:0] rd_left_ff, rd_upper_ff, rd_right_ff, rd_lower_ff;

   always_ff @(posedge clock) begin
      if (cmd.rd) begin
         rd_present_ff <= st_present[rd_index];
         rd_left_ff    <= st_left[rd_index];
         rd_upper_ff   <= st_upper[rd_index];
         rd_right_ff   <= st_right[rd_index];
         rd_lower_ff   <= st_lower[rd_index];
      end
   end

   ival_type rl, ru, rr, rlo;
   assign rl  = signed'(IW'(rd_left_ff));
   assign ru  = signed'(IW'(rd_upper_ff));
   assign rr  = signed'(IW'(rd_right_ff));
   assign rlo = signed'(IW'(rd_lower_ff));

   // move request capture
   logic signed [FIELD_W-1:0] x0_ff, y0_ff, x1_ff, y1_ff, w_ff, h_ff;
   logic                      inv_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         x0_ff  <= in_x0;
         y0_ff  <= in_y0;
         x1_ff  <= in_x1;
         y1_ff  <= in_y1;
         w_ff   <= in_w;
         h_ff   <= in_h;
         inv_ff <= in_inv;
      end
   end

   // stage 1: logical coordinates with graphic origin
   ival_type fx1_ff, fy1_ff, tx1_ff, ty1_ff, w1_ff, h1_ff;

   always_ff @(posedge clock) begin
      if (cmd.m1) begin
         fx1_ff <= IW'(x0_ff) + IW'(org_x_ff);
         fy1_ff <= IW'(y0_ff) + IW'(org_y_ff);
         tx1_ff <= IW'(x1_ff) + IW'(org_x_ff);
         ty1_ff <= IW'(y1_ff) + IW'(org_y_ff);
         w1_ff  <= IW'(w_ff);
         h1_ff  <= IW'(h_ff);
      end
   end

   // stage 2: window check, absolute portrait coordinates
   ival_type ww_s, wh_s, wl_s, wt_s;
   assign ww_s = signed'(IW'(win_width_ff));
   assign wh_s = signed'(IW'(win_height_ff));
   assign wl_s = signed'(IW'(win_left_ff));
   assign wt_s = signed'(IW'(win_top_ff));

   logic     ok_ff;
   ival_type fxa_ff, fya_ff, txa_ff, tya_ff, wm_ff, hm_ff;

   always_ff @(posedge clock) begin
      if (cmd.m2) begin
         ok_ff <= w1_ff > 0 && h1_ff > 0 && fx1_ff >= 0 && fy1_ff >= 0 &&
                  tx1_ff >= 0 && ty1_ff >= 0 &&
                  tx1_ff + w1_ff <= ww_s && fx1_ff + w1_ff <= ww_s &&
                  ty1_ff + h1_ff <= wh_s && fy1_ff + h1_ff <= wh_s;
         fxa_ff <= fx1_ff + wl_s;
         txa_ff <= tx1_ff + wl_s;
         fya_ff <= wt_s + wh_s - fy1_ff - h1_ff;
         tya_ff <= wt_s + wh_s - ty1_ff - h1_ff;
         wm_ff  <= w1_ff - 1;
         hm_ff  <= h1_ff - 1;
      end
   end

   // stage 3: far corner, offsets, copy direction
   ival_type fxw_ff, fyh_ff, offx_ff, offy_ff;
   logic     dx_down_ff, dy_down_ff;

   always_ff @(posedge clock) begin
      if (cmd.m3) begin
         fxw_ff     <= fxa_ff + wm_ff;
         fyh_ff     <= fya_ff + hm_ff;
         offx_ff    <= txa_ff - fxa_ff;
         offy_ff    <= tya_ff - fya_ff;
         dx_down_ff <= txa_ff > fxa_ff;
         dy_down_ff <= tya_ff > fya_ff;
      end
   end

   // source rectangle clip; hit is decided in the calc cycle itself
   logic     s_hit_c;
   ival_type sleft_ff, sup_ff, dleft_ff, dright_ff, dup_ff, dlow_ff;
   ival_type sleft_c, sup_c, sright_c, slow_c;

   assign sleft_c  = (rl > fxa_ff) ? rl : fxa_ff;
   assign sup_c    = (ru > fya_ff) ? ru : fya_ff;
   assign sright_c = (fxw_ff < rr) ? fxw_ff : rr;
   assign slow_c   = (fyh_ff < rlo) ? fyh_ff : rlo;
   assign s_hit_c  = rd_present_ff && !(rr < fxa_ff) && !(rl > fxw_ff) &&
                     !(rlo < fya_ff) && !(ru > fyh_ff);

   always_ff @(posedge clock) begin
      if (cmd.src_calc) begin
         sleft_ff  <= sleft_c;
         sup_ff    <= sup_c;
         dleft_ff  <= sleft_c + offx_ff;
         dright_ff <= sright_c + offx_ff;
         dup_ff    <= sup_c + offy_ff;
         dlow_ff   <= slow_c + offy_ff;
      end
   end

   // destination rectangle clip
   logic     d_hit_c;
   ival_type xs_ff, xd_ff, xsz_ff, ys_ff, yd_ff, ysz_ff;
   ival_type xd_c, yd_c, xr_c, yl_c;

   assign xd_c    = (dleft_ff < rl) ? rl : dleft_ff;
   assign yd_c    = (dup_ff < ru) ? ru : dup_ff;
   assign xr_c    = (dright_ff > rr) ? rr : dright_ff;
   assign yl_c    = (dlow_ff > rlo) ? rlo : dlow_ff;
   assign d_hit_c = rd_present_ff && !(rr < dleft_ff) && !(rl > dright_ff) &&
                    !(rlo < dup_ff) && !(ru > dlow_ff);

   always_ff @(posedge clock) begin
      if (cmd.dst_calc) begin
         xd_ff    <= xd_c;
         xs_ff    <= sleft_ff + (xd_c - dleft_ff);
         xsz_ff   <= xr_c - xd_c;
         yd_ff    <= yd_c;
         ys_ff    <= sup_ff + (yd_c - dup_ff);
         ysz_ff   <= yl_c - yd_c;
      end
   end

   assign stat.ok    = ok_ff;
   assign stat.s_hit = s_hit_c;
   assign stat.d_hit = d_hit_c;

   // blit fields, start corner per direction
   ival_type sx_c, sy_c, dx_c, dy_c, cx_c, cy_c;

   always_comb begin
      if (dx_down_ff) begin
         sx_c = xs_ff + xsz_ff;
         dx_c = xd_ff + xsz_ff;
         cx_c = -xsz_ff;
      end else begin
         sx_c = xs_ff;
         dx_c = xd_ff;
         cx_c = xsz_ff;
      end
      if (dy_down_ff) begin
         sy_c = ys_ff + ysz_ff;
         dy_c = yd_ff + ysz_ff;
         cy_c = -ysz_ff;
      end else begin
         sy_c = ys_ff;
         dy_c = yd_ff;
         cy_c = ysz_ff;
      end
   end

   logic [RSP_TDATA_W-1:0] pend_ff;

   always_ff @(posedge clock) begin
      if (cmd.pair_load) begin
         pend_ff <= {3'b000, inv_ff, dy_down_ff, dx_down_ff,
                     cy_c[FIELD_W-1:0], cx_c[OUT_CX_W-1:0],
                     dy_c[OUT_XY_W-1:0], dx_c[OUT_XY_W-1:0],
                     sy_c[OUT_XY_W-1:0], sx_c[OUT_XY_W-1:0]};
      end
      if (cmd.out_load) begin
         rsp_tdata <= pend_ff;
         rsp_tlast <= cmd.out_last;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/camsplit_ctrl.sv =====
`default_nettype none
module camsplit_ctrl #(
   parameter int IXW = 3,
   parameter int CW  = 4
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   input  wire logic                   req_tuser,
   output logic                        req_tready,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   input  wire camsplit_pkg::stat_type stat,
   input  wire logic [CW-1:0]          slot_count,
   output camsplit_pkg::cmd_type       cmd,
   output logic [IXW-1:0]              rd_index
);
   import camsplit_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_M1, S_M2, S_M3, S_SRC_RD, S_SRC_CALC,
      S_DST_RD, S_DST_CALC, S_PAIR, S_FINISH
   } state_type;

   state_type      state_ff;
   logic [CW-1:0]  i_ff, j_ff;
   logic           pend_valid_ff;
   logic           out_free;

   assign out_free   = !rsp_tvalid || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      cmd           = '0;
      cmd.capture   = (state_ff == S_IDLE) && req_tvalid;
      cmd.m1        = (state_ff == S_M1);
      cmd.m2        = (state_ff == S_M2);
      cmd.m3        = (state_ff == S_M3);
      cmd.rd        = (state_ff == S_SRC_RD && i_ff != slot_count) ||
                      (state_ff == S_DST_RD && j_ff != slot_count);
      cmd.src_calc  = (state_ff == S_SRC_CALC);
      cmd.dst_calc  = (state_ff == S_DST_CALC);
      cmd.pair_load = (state_ff == S_PAIR) && (!pend_valid_ff || out_free);
      cmd.out_load  = (state_ff == S_PAIR || state_ff == S_FINISH) &&
                      pend_valid_ff && out_free;
      cmd.out_last  = (state_ff == S_FINISH);
      rd_index      = (state_ff == S_DST_RD) ? j_ff[IXW-1:0] : i_ff[IXW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         i_ff          <= '0;
         j_ff          <= '0;
         pend_valid_ff <= 1'b0;
         rsp_tvalid    <= 1'b0;
      end else begin
         if (cmd.out_load)
            rsp_tvalid <= 1'b1;
         else if (rsp_tready)
            rsp_tvalid <= 1'b0;

         unique case (state_ff)
            S_IDLE: begin
               if (req_tvalid && req_tuser == REQ_MOVE)
                  state_ff <= S_M1;
            end
            S_M1: state_ff <= S_M2;
            S_M2: state_ff <= S_M3;
            S_M3: begin
               i_ff     <= '0;
               state_ff <= stat.ok ? S_SRC_RD : S_IDLE;
            end
            S_SRC_RD: state_ff <= (i_ff == slot_count) ? S_FINISH : S_SRC_CALC;
            S_SRC_CALC: begin
               if (stat.s_hit) begin
                  j_ff     <= '0;
                  state_ff <= S_DST_RD;
               end else begin
                  i_ff     <= i_ff + 1'b1;
                  state_ff <= S_SRC_RD;
               end
            end
            S_DST_RD: begin
               if (j_ff == slot_count) begin
                  i_ff     <= i_ff + 1'b1;
                  state_ff <= S_SRC_RD;
               end else begin
                  state_ff <= S_DST_CALC;
               end
            end
            S_DST_CALC: begin
               if (stat.d_hit) begin
                  state_ff <= S_PAIR;
               end else begin
                  j_ff     <= j_ff + 1'b1;
                  state_ff <= S_DST_RD;
               end
            end
            S_PAIR: begin
               // the previous blit goes out only once a newer one proves it is not last
               if (!pend_valid_ff || out_free) begin
                  pend_valid_ff <= 1'b1;
                  j_ff          <= j_ff + 1'b1;
                  state_ff      <= S_DST_RD;
               end
            end
            S_FINISH: begin
               if (!pend_valid_ff) begin
                  state_ff <= S_IDLE;
               end else if (out_free) begin
                  pend_valid_ff <= 1'b0;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule
`default_nettype wire

// ===== rtl/clipped_area_move_splitter.sv =====
`default_nettype none
// Clipped area move splitter.
// req_ channel: tuser=0 loads one visible window rectangle into slot rect_index,
//   tuser=1 asks for an area move. A load never stalls the input; the next
//   item may follow right after it.
// rsp_ channel: one blit command per overlapping source/destination rectangle
//   pair, tlast on the final one. A move that is empty, leaves the window or
//   hits no pair produces nothing.
// csr_ channel: register writes (window geometry, graphic origin, slot count),
//   always ready; write only while no move is in flight.
// Flow: a move passes states M1, M2 and M3 (origin, window check, far corner),
//   then walks the source slots with a store read and a clip state each, and
//   for each visible source slot walks the destination slots the same way;
//   each walk ends on a read past the last slot. Each blit takes a pair state
//   and a finish state ends the move. The single store read port and the pair
//   walk set the pace. The first blit is offered only once the walk reaches
//   the next blit or its end.
// A stalled rsp_ side holds the walk at the next blit; one blit waits in a
// pending register so tlast can be decided.
// Reset clears control and config registers; the store holds garbage until
// loaded.
module clipped_area_move_splitter #(
   parameter int MAX_RECTS  = 8,
   parameter int COORD_BITS = 11
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // rect_index[2:0] rect_present[3] x0[15:4] y0[27:16] x1[39:28] y1[51:40]
   // area_width[63:52] area_height[75:64] invert_req[76], zero pad
   input  wire logic [camsplit_pkg::REQ_TDATA_W-1:0] req_tdata,
   // req_type[0]
   input  wire logic                                 req_tuser,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // src_x[10:0] src_y[21:11] dst_x[32:22] dst_y[43:33] count_x[53:44]
   // count_y[65:54] direction[67:66] invert[68], zero pad
   output logic [camsplit_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   output logic                                      rsp_tlast,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [camsplit_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [camsplit_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import camsplit_pkg::*;

   localparam int IXW = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
   localparam int CW  = $clog2(MAX_RECTS + 1);

   cmd_type        cmd;
   stat_type       stat;
   logic [IXW-1:0] rd_index;
   logic [CW-1:0]  slot_count;

   assign csr_ready = 1'b1;

   camsplit_ctrl #(.IXW(IXW), .CW(CW)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .slot_count (slot_count),
      .cmd        (cmd),
      .rd_index   (rd_index)
   );

   camsplit_dpath #(
      .MAX_RECTS(MAX_RECTS), .COORD_BITS(COORD_BITS), .IXW(IXW), .CW(CW)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .rd_index   (rd_index),
      .stat       (stat),
      .slot_count (slot_count),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // a move keeps the input side closed while it is worked
   a_move_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == REQ_MOVE |=> !req_tready)
      else $error("input accepted during a move");

   // loads never stall the input side
   a_load_quick: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == REQ_LOAD |=> req_tready)
      else $error("load held the input side");

endmodule
`default_nettype wire
